@@ rtl/bse_pkg.sv @@
// Shared types and constants for the bitmap sweep address emitter.
`timescale 1ns / 1ps

package bse_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int BITMAP_W    = 32;
    localparam int INDEX_W     = 20;
    localparam int COUNT_W     = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_COUNT = 2'd1;

    // One filtered bitmap word on its way to the emitter
    typedef struct packed {
        logic [ADDR_W-1:0]   word_base;
        logic [BITMAP_W-1:0] garbage;
    } bse_word_t;

endpackage

@@ rtl/bse_ifs.sv @@
// Stream interfaces for bitmap words in and object addresses out.
`timescale 1ns / 1ps

interface bse_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] live_word;
    logic [31:0] mark_word;
    logic [19:0] word_index;

    modport source (output valid, output live_word, output mark_word, output word_index,
                    input ready);
    modport sink   (input valid, input live_word, input mark_word, input word_index,
                    output ready);
endinterface

interface bse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] object_address;
    logic        last_of_word;

    modport source (output valid, output object_address, output last_of_word,
                    input ready);
    modport sink   (input valid, input object_address, input last_of_word,
                    output ready);
endinterface

@@ rtl/bse_prep.sv @@
// Front stages: garbage extraction, range filter and word base address.
`timescale 1ns / 1ps

module bse_prep #(
    parameter int WORD_BITS   = 32,
    parameter int ALIGN_BYTES = 8,
    parameter int MAX_WORDS   = 1048576
) (
    input  logic                    clk,
    input  logic                    rst_n,
    bse_in_if.sink                  bitmap,
    input  logic [31:0]             heap_base,
    input  logic [20:0]             sweep_word_count,
    output logic                    link_valid,
    input  logic                    link_ready,
    output bse_pkg::bse_word_t      link_word
);
    import bse_pkg::*;

    localparam logic [BITMAP_W-1:0] WORD_MASK = (WORD_BITS >= BITMAP_W) ? '1 :
        BITMAP_W'((64'd1 << WORD_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(WORD_BITS * ALIGN_BYTES);
    localparam logic [31:0]       MAX_W32 = 32'(MAX_WORDS);

    logic                s1_valid_reg, s1_valid_next;
    logic [BITMAP_W-1:0] s1_garbage_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic                s1_ready;
    logic                s2_valid_reg, s2_valid_next;
    bse_word_t           s2_word_reg;
    logic                s2_ready;
    logic [BITMAP_W-1:0] garbage;
    logic                in_range;
    logic                take_in;

    // Stage 1: live and not marked, inside the swept range
    assign garbage  = bitmap.live_word & ~bitmap.mark_word & WORD_MASK;
    assign in_range = (32'(bitmap.word_index) < 32'(sweep_word_count)) &&
                      (32'(bitmap.word_index) < MAX_W32);
    assign s2_ready = !s2_valid_reg || link_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign bitmap.ready = s1_ready;
    assign take_in  = bitmap.valid && s1_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
        begin
            s1_valid_next = in_range && (garbage != '0);
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_garbage_reg <= garbage;
            s1_index_reg   <= bitmap.word_index;
        end
    end

    // Stage 2: word base = heap base + index * word stride
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg.word_base <= heap_base + ADDR_W'(s1_index_reg) * STRIDE;
            s2_word_reg.garbage   <= s1_garbage_reg;
        end
    end

    assign link_valid = s2_valid_reg;
    assign link_word  = s2_word_reg;

endmodule

@@ rtl/bse_emitter.sv @@
// Back stages: msb-first garbage bit scan and the output register.
`timescale 1ns / 1ps

module bse_emitter #(
    parameter int WORD_BITS   = 32,
    parameter int ALIGN_BYTES = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    link_valid,
    output logic                    link_ready,
    input  bse_pkg::bse_word_t      link_word,
    bse_out_if.source               garbage
);
    import bse_pkg::*;

    localparam int SCAN_W = (WORD_BITS < BITMAP_W) ? WORD_BITS : BITMAP_W;

    logic                busy_reg, busy_next;
    logic [BITMAP_W-1:0] vec_reg, vec_next;
    logic [ADDR_W-1:0]   base_reg;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic                last_reg;
    logic                out_free;
    logic                emit;
    logic [BITMAP_W-1:0] hit;
    logic [ADDR_W-1:0]   offset;
    logic [BITMAP_W-1:0] rest;
    logic                last_bit;

    // Highest set bit is the lowest address; its offset is a per-bit constant
    always_comb
    begin
        hit    = '0;
        offset = '0;
        for (int j = 0; j < SCAN_W; j++)
        begin
            if (vec_reg[j])
            begin
                hit    = BITMAP_W'(1) << j;
                offset = ADDR_W'((WORD_BITS - 1 - j) * ALIGN_BYTES);
            end
        end
    end

    assign rest       = vec_reg & ~hit;
    assign last_bit   = (rest == '0);
    assign out_free   = !out_valid_reg || garbage.ready;
    assign emit       = busy_reg && out_free;
    assign link_ready = !busy_reg || (emit && last_bit);

    // Scan state
    always_comb
    begin
        busy_next = busy_reg;
        vec_next  = vec_reg;
        if (link_valid && link_ready)
        begin
            busy_next = 1'b1;
            vec_next  = link_word.garbage;
        end
        else if (emit)
        begin
            busy_next = !last_bit;
            vec_next  = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
        if (link_valid && link_ready)
        begin
            base_reg <= link_word.word_base;
        end
    end

    // Output register
    assign out_valid_next = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            addr_reg <= base_reg + offset;
            last_reg <= last_bit;
        end
    end

    assign garbage.valid          = out_valid_reg;
    assign garbage.object_address = addr_reg;
    assign garbage.last_of_word   = last_reg;

endmodule

@@ rtl/bitmap_sweep_address_emitter.sv @@
// Top level: configuration registers, front stages and address emitter.
`timescale 1ns / 1ps

// Sweep-phase helper for a mark-sweep collector. The bitmap channel takes one
// live word, the matching mark word and the word index per transfer. The
// garbage channel returns one heap byte address per live, unmarked object,
// lowest address first, with last_of_word set on the final address of a word.
// Words past the sweep word count, or with no garbage, produce nothing.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 heap base,
// 1 sweep word count); write only while the block is idle.
// Path: the transfer loads stage one; the word then passes to stage two, the
// emitter load and the output register before its first address is valid.
// Throughput: the bitmap side takes one word per cycle while the emitter keeps
// up; the emitter scan gives one address per cycle while the output is not
// stalled, and loads a new word in the cycle it emits the last address of the
// current one. Words without garbage are dropped before the emitter.
// Reset clears all valid bits and both registers to zero. A stall on the
// garbage channel holds the output register and backs up through the stages
// without losing or repeating anything.
module bitmap_sweep_address_emitter #(
    parameter int WORD_BITS   = 32,
    parameter int ALIGN_BYTES = 8,
    parameter int MAX_WORDS   = 1048576
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bse_in_if.sink                               bitmap,
    bse_out_if.source                            garbage,
    input  logic                                 cfg_we,
    input  logic [bse_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bse_pkg::*;

    logic [ADDR_W-1:0]  heap_base_reg, heap_base_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               link_valid;
    logic               link_ready;
    bse_word_t          link_word;

    // Configuration decode
    always_comb
    begin
        heap_base_next = heap_base_reg;
        count_next     = count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAP_BASE:   heap_base_next = cfg_data;
                REG_SWEEP_COUNT: count_next     = cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
            count_reg     <= count_next;
        end
    end

    bse_prep #(
        .WORD_BITS   (WORD_BITS),
        .ALIGN_BYTES (ALIGN_BYTES),
        .MAX_WORDS   (MAX_WORDS)
    ) u_prep (
        .clk              (clk),
        .rst_n            (rst_n),
        .bitmap           (bitmap),
        .heap_base        (heap_base_reg),
        .sweep_word_count (count_reg),
        .link_valid       (link_valid),
        .link_ready       (link_ready),
        .link_word        (link_word)
    );

    bse_emitter #(
        .WORD_BITS   (WORD_BITS),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link_word  (link_word),
        .garbage    (garbage)
    );

    // Only words with garbage reach the emitter
    assert property (@(posedge clk) disable iff (!rst_n)
        link_valid |-> (link_word.garbage != '0))
        else $error("empty word passed to emitter");

    // A stalled word between the stages holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (link_valid && !link_ready) |=> (link_valid && $stable(link_word)))
        else $error("stalled link word changed");

    // Addresses of one word follow each other without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (garbage.valid && garbage.ready && !garbage.last_of_word) |=> garbage.valid)
        else $error("gap inside a word's addresses");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the bitmap sweep address emitter.
`timescale 1ns / 1ps

module tb;
    import bse_pkg::*;

    localparam int WORD_BITS       = 32;
    localparam int ALIGN_BYTES     = 8;
    localparam int MAX_WORDS       = 1048576;
    localparam int INDEX_MAX       = (1 << INDEX_W) - 1;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WORDS_PER_PHASE = 66;

    // Register indexes the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {GAP_NONE, GAP_FULL, GAP_RARE} gap_mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              last;
    } garbage_addr_t;

    // Shadow registers, address predictor and queue of addresses still owed
    class sweep_scoreboard_t;
        logic [ADDR_W-1:0]  heap_base;
        logic [COUNT_W-1:0] sweep_count;
        garbage_addr_t      pending_addresses[$];
        int                 words_noted;
        int                 words_swept;
        int                 checked;
        int                 mismatches;

        function new();
            heap_base   = '0;
            sweep_count = '0;
            words_noted = 0;
            words_swept = 0;
            checked     = 0;
            mismatches  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HEAP_BASE:   heap_base   = data[ADDR_W-1:0];
                REG_SWEEP_COUNT: sweep_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Counts past the bitmap size behave as the bitmap size
        function int sweep_limit();
            return (sweep_count > MAX_WORDS) ? MAX_WORDS : int'(sweep_count);
        endfunction

        function void note_bitmap_word(logic [BITMAP_W-1:0] live,
                                       logic [BITMAP_W-1:0] mark,
                                       logic [INDEX_W-1:0] idx);
            logic [BITMAP_W-1:0] garbage_bits;
            logic [ADDR_W-1:0]   word_base;
            garbage_addr_t       entry;
            words_noted++;
            if (idx >= sweep_limit())
                return;
            words_swept++;
            garbage_bits = live & ~mark;
            word_base = heap_base + ADDR_W'(idx) * ADDR_W'(WORD_BITS * ALIGN_BYTES);
            // msb first: lowest address first, all sums wrap at 32 bits
            for (int b = WORD_BITS - 1; b >= 0; b--)
            begin
                if (garbage_bits[b])
                begin
                    entry.address = word_base + ADDR_W'((WORD_BITS - 1 - b) * ALIGN_BYTES);
                    entry.last    = 1'b0;
                    pending_addresses.push_back(entry);
                end
            end
            if (garbage_bits != '0)
                pending_addresses[pending_addresses.size() - 1].last = 1'b1;
        endfunction

        function void check_garbage_address(logic [ADDR_W-1:0] address, logic last);
            garbage_addr_t want;
            checked++;
            if (pending_addresses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected garbage address %h (last %b)", address, last);
                return;
            end
            want = pending_addresses.pop_front();
            if (address !== want.address || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Garbage address %0d: expected %h last %b, got %h last %b",
                             checked, want.address, want.last, address, last);
            end
        endfunction

        function int pending();
            return pending_addresses.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    gap_mode_t              bitmap_gap_mode;
    gap_mode_t              garbage_gap_mode;
    int                     sink_wait;
    int                     settings;
    sweep_scoreboard_t      sb;

    bse_in_if  bitmap_ch ();
    bse_out_if garbage_ch ();

    bitmap_sweep_address_emitter #(
        .WORD_BITS   (WORD_BITS),
        .ALIGN_BYTES (ALIGN_BYTES),
        .MAX_WORDS   (MAX_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bitmap    (bitmap_ch),
        .garbage   (garbage_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap(input gap_mode_t mode);
        case (mode)
            GAP_NONE: return 0;
            GAP_FULL: return $urandom_range(0, 16);
            default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Garbage side: check each transfer, then stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            garbage_ch.ready <= 1'b0;
            sink_wait = 0;
        end
        else if (garbage_ch.ready)
        begin
            if (garbage_ch.valid)
            begin
                sb.check_garbage_address(garbage_ch.object_address, garbage_ch.last_of_word);
                sink_wait = draw_gap(garbage_gap_mode);
                if (sink_wait > 0)
                    garbage_ch.ready <= 1'b0;
            end
        end
        else if (sink_wait > 1)
            sink_wait--;
        else
            garbage_ch.ready <= 1'b1;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] base,
                                 input logic [CFG_DATA_W-1:0] count_data);
        write_reg(REG_HEAP_BASE, base);
        write_reg(REG_SWEEP_COUNT, count_data);
        settings++;
    endtask

    // One bitmap transfer after a drawn idle gap
    task automatic send_word(input logic [BITMAP_W-1:0] live,
                             input logic [BITMAP_W-1:0] mark,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        gap = draw_gap(bitmap_gap_mode);
        if (gap > 0)
        begin
            bitmap_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bitmap_ch.valid      <= 1'b1;
        bitmap_ch.live_word  <= live;
        bitmap_ch.mark_word  <= mark;
        bitmap_ch.word_index <= idx;
        do @(posedge clk); while (!bitmap_ch.ready);
        sb.note_bitmap_word(live, mark, idx);
    endtask

    // Wait for every owed address, then for words with no garbage to drain
    task automatic settle_block();
        bitmap_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] base,
                                    input logic [CFG_DATA_W-1:0] count_data,
                                    input gap_mode_t bmode,
                                    input gap_mode_t gmode);
        logic [BITMAP_W-1:0] live;
        logic [BITMAP_W-1:0] mark;
        logic [INDEX_W-1:0]  idx;
        int                  limit;
        int                  swept;
        apply_setting(base, count_data);
        bitmap_gap_mode  = bmode;
        garbage_gap_mode = gmode;
        limit = sb.sweep_limit();
        swept = 0;
        while (swept < WORDS_PER_PHASE)
        begin
            // Mostly moderate garbage density, plus near-full, sparse and single-bit words
            case ($urandom_range(0, 9))
                0: begin live = '1; mark = $urandom & $urandom & $urandom; end
                1: begin live = $urandom; mark = ~live | $urandom; end
                2: begin live = BITMAP_W'(1) << $urandom_range(0, BITMAP_W - 1); mark = '0; end
                default: begin live = $urandom; mark = $urandom & $urandom; end
            endcase
            // Mostly inside the sweep count, some on its edge or past it
            case ($urandom_range(0, 19))
                0: idx = INDEX_W'(limit - 1);
                1, 2, 3:
                    if (limit <= INDEX_MAX)
                        idx = INDEX_W'($urandom_range(limit, INDEX_MAX));
                    else
                        idx = INDEX_W'($urandom_range(0, limit - 1));
                default: idx = INDEX_W'($urandom_range(0, limit - 1));
            endcase
            send_word(live, mark, idx);
            if (idx < limit)
                swept++;
        end
        settle_block();
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] count_data;
        sb               = new();
        settings         = 0;
        bitmap_gap_mode  = GAP_FULL;
        garbage_gap_mode = GAP_FULL;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_HEAP_BASE;
        cfg_data             <= '0;
        bitmap_ch.valid      <= 1'b0;
        bitmap_ch.live_word  <= '0;
        bitmap_ch.mark_word  <= '0;
        bitmap_ch.word_index <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: empty heap, nothing comes out
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'h00000);
        send_word(32'hA5A5_A5A5, 32'h0000_0000, 20'hFFFFF);
        settle_block();

        // Small heap: full, empty, fully marked, single-bit and count-edge words
        apply_setting(32'h8000_0000, 32'd16);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'd0);
        send_word(32'h0000_0000, 32'h0000_0000, 20'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd2);
        send_word(32'h8000_0000, 32'h0000_0000, 20'd15);
        send_word(32'h0000_0001, 32'h0000_0000, 20'd3);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'd16);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'hFFFFF);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 20'd5);
        send_word(32'h5555_5555, 32'h0000_0000, 20'd7);
        send_word(32'h0F0F_0F0F, 32'h00FF_00FF, 20'd9);
        settle_block();

        // Top base with an oversize count: addresses wrap past 2^32
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'hFFFFF);
        send_word(32'h8000_0001, 32'h0000_0000, 20'd0);
        settle_block();

        // Count exactly the bitmap size, then one less
        apply_setting(32'h0000_0100, MAX_WORDS);
        send_word(32'hFFFF_0000, 32'h0000_FFFF, 20'hFFFFF);
        settle_block();
        apply_setting(32'h0000_0100, INDEX_MAX);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'hFFFFF);
        send_word(32'h1234_5678, 32'h0000_0000, 20'hFFFFE);
        settle_block();

        // Writes to undecoded indexes must leave both registers alone
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 20'hFFFFE);
        settle_block();

        // Random phases over varied settings and idle patterns
        count_data = $urandom;
        if (count_data[COUNT_W-1:0] == '0)
            count_data[0] = 1'b1;
        run_random_phase($urandom, count_data, GAP_FULL, GAP_FULL);
        run_random_phase(32'h0000_0000, 32'd1, GAP_NONE, GAP_NONE);
        run_random_phase(32'hFFFF_FFFF, MAX_WORDS, GAP_RARE, GAP_FULL);
        run_random_phase($urandom, $urandom_range(2, 64), GAP_FULL, GAP_NONE);
        write_reg(REG_SPARE_2, $urandom);
        write_reg(REG_SPARE_3, $urandom);
        run_random_phase($urandom, 32'hFFFF_FFFF, GAP_NONE, GAP_RARE);
        run_random_phase($urandom, $urandom_range(1, INDEX_MAX), GAP_FULL, GAP_RARE);

        $display("Swept %0d bitmap words (%0d inside the sweep count) over %0d register settings",
                 sb.words_noted, sb.words_swept, settings);
        $display("Checked %0d garbage addresses, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
